// File: rtl/core/axis_mean_intensity_projection_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mean intensity projection block
// Short forms of the concurrent checks, sampled on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef AXIS_MEAN_INTENSITY_PROJECTION_MACROS_SVH
`define AXIS_MEAN_INTENSITY_PROJECTION_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define AMIP_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AMIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/amip_pkg.sv
// ----------------------------------------------------------------------------
// amip_pkg
// Shared constants, register codes and types of the projection block.
// ----------------------------------------------------------------------------
package amip_pkg;

	// Parameter defaults.
	localparam int MAX_DIM_DEF     = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 9;
	localparam int SIZE_CFG_W  = 9;
	localparam int AXIS_W      = 2;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_AXIS_MODE = 3'd0,
		REG_SIZE_X    = 3'd1,
		REG_SIZE_Y    = 3'd2,
		REG_SIZE_Z    = 3'd3
	} cfg_reg_t;

	// Projection axis codes; the reserved code acts as the z axis.
	typedef enum logic [AXIS_W-1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// Divider sequencer states.
	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_HOLD
	} div_state_t;

	// Control from the accumulator stage to the divider.
	typedef struct packed {
		logic start;
		logic image_done;
		logic take;
	} div_ctl_t;

	// Status from the divider.
	typedef struct packed {
		logic idle;
		logic valid;
		logic image_done;
	} div_stat_t;

endpackage

// File: rtl/core/amip_ifs.sv
// ----------------------------------------------------------------------------
// amip channel interfaces
// Valid/ready channels for voxels, projected pixels and register writes.
// ----------------------------------------------------------------------------

// Voxel input channel.
interface amip_voxel_if import amip_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] voxel_value;

	modport source (output valid, output voxel_value, input ready);
	modport sink (input valid, input voxel_value, output ready);
endinterface

// Projected pixel output channel.
interface amip_pixel_if import amip_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] mean_value;
	logic                   image_done;

	modport source (output valid, output mean_value, output image_done, input ready);
	modport sink (input valid, input mean_value, input image_done, output ready);
endinterface

// Register write channel.
interface amip_cfg_if import amip_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/amip_div.sv
// ----------------------------------------------------------------------------
// amip_div
// Restoring divider, one quotient bit per cycle, holding its result until taken.
// ----------------------------------------------------------------------------
module amip_div import amip_pkg::*; #(
	parameter int SUM_W = SAMPLE_BITS_DEF + 8,
	parameter int SZ_W  = 9,
	parameter int Q_W   = SAMPLE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	input  logic [SUM_W-1:0] dividend,
	input  logic [SZ_W-1:0]  divisor,
	output div_stat_t        stat,
	output logic [Q_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(SUM_W);

	div_state_t       state_q;
	div_state_t       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] dvd_q;
	logic [SZ_W-1:0]  rem_q;
	logic [SZ_W-1:0]  dsr_q;
	logic             done_q;
	logic [SZ_W:0]    rem_sh;
	logic             ge;
	logic [SZ_W:0]    rem_diff;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		rem_sh   = {rem_q, dvd_q[SUM_W-1]};
		ge       = (rem_sh >= {1'b0, dsr_q});
		rem_diff = rem_sh - {1'b0, dsr_q};
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and status.
	always_comb begin
		state_d         = state_q;
		stat.idle       = 1'b0;
		stat.valid      = 1'b0;
		stat.image_done = done_q;
		unique case (state_q)
			DIV_IDLE: begin
				stat.idle = 1'b1;
				if (ctl.start) begin
					state_d = DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (cnt_q == '0) begin
					state_d = DIV_HOLD;
				end
			end
			DIV_HOLD: begin
				stat.valid = 1'b1;
				if (ctl.take) begin
					state_d = DIV_IDLE;
				end
			end
			default: begin
				state_d = DIV_IDLE;
			end
		endcase
	end

	// Datapath: the dividend register collects quotient bits from the bottom.
	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && ctl.start) begin
			dvd_q  <= dividend;
			dsr_q  <= divisor;
			rem_q  <= '0;
			cnt_q  <= CNT_W'(SUM_W - 1);
			done_q <= ctl.image_done;
		end else if (state_q == DIV_RUN) begin
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			rem_q <= ge ? rem_diff[SZ_W-1:0] : rem_sh[SZ_W-1:0];
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// The mean never exceeds the sample range.
	assign quotient = dvd_q[Q_W-1:0];

endmodule

// File: rtl/core/axis_mean_intensity_projection.sv
// Rate: a voxel is taken every cycle unless a line end ahead of it waits for the divider.
// A voxel that ends a line starts the shared divider, which takes one quotient bit a
// cycle; its sum passes the divider and then the output register to the pixel port.
// The divider serves one line end at a time; a further line end waits until it is idle.
// Reset clears positions, registers and handshake state; the sum memory is not
// cleared, since the first voxel of every line overwrites its entry.
// ----------------------------------------------------------------------------
// axis_mean_intensity_projection
// Streams a raster-ordered volume and emits the per-line mean along an axis,
// accumulating line sums in a read-modify-write memory.
// ----------------------------------------------------------------------------
`include "axis_mean_intensity_projection_macros.svh"

module axis_mean_intensity_projection import amip_pkg::*; #(
	parameter int MAX_DIM     = MAX_DIM_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	amip_cfg_if.sink     cfg,
	amip_voxel_if.sink   voxel,
	amip_pixel_if.source pixel
);

	localparam int POS_W  = $clog2(MAX_DIM);
	localparam int SZ_W   = $clog2(MAX_DIM + 1);
	localparam int SUM_W  = SAMPLE_BITS + POS_W;
	localparam int ADDR_W = 2 * POS_W;
	localparam int DEPTH  = 1 << ADDR_W;

	// Configuration registers.
	logic [AXIS_W-1:0]     axis_q;
	logic [SIZE_CFG_W-1:0] size_x_q;
	logic [SIZE_CFG_W-1:0] size_y_q;
	logic [SIZE_CFG_W-1:0] size_z_q;
	logic                  cfg_wr;
	logic                  cfg_hit;

	// Position of the next voxel.
	logic [POS_W-1:0] pos_x_q;
	logic [POS_W-1:0] pos_y_q;
	logic [POS_W-1:0] pos_z_q;

	// Input stage signals.
	logic [SZ_W-1:0]   sx;
	logic [SZ_W-1:0]   sy;
	logic [SZ_W-1:0]   sz;
	logic [POS_W-1:0]  x_s0;
	logic [POS_W-1:0]  y_s0;
	logic [POS_W-1:0]  z_s0;
	logic              last_x;
	logic              last_y;
	logic              last_z;
	logic [ADDR_W-1:0] addr_s0;
	logic              first_s0;
	logic              emit_s0;
	logic              done_s0;
	logic [SZ_W-1:0]   len_s0;
	logic [POS_W-1:0]  nx_x;
	logic [POS_W-1:0]  nx_y;
	logic [POS_W-1:0]  nx_z;
	logic              voxel_acc;

	// Accumulate stage.
	logic                   valid_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic [SAMPLE_BITS-1:0] val_s1;
	logic                   first_s1;
	logic                   emit_s1;
	logic                   done_s1;
	logic [SZ_W-1:0]        len_s1;
	logic                   fwd_s1;
	logic [SUM_W-1:0]       fwd_data_s1;
	logic [SUM_W-1:0]       rdata_s1;
	logic [SUM_W-1:0]       sum_s1;
	logic                   s1_fire;

	// Line sum memory.
	logic [SUM_W-1:0] sums_mem [DEPTH];

	// Divider and output register.
	div_ctl_t               div_ctl;
	div_stat_t              div_stat;
	logic [SAMPLE_BITS-1:0] div_q;
	logic                   out_take;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_mean_q;
	logic                   out_done_q;

	// Sizes of 0 act as 1, sizes beyond the memory act as its full extent.
	function automatic logic [SZ_W-1:0] clamp_size(input logic [SIZE_CFG_W-1:0] s);
		if (s == '0) begin
			return SZ_W'(1);
		end else if (int'(s) > MAX_DIM) begin
			return SZ_W'(MAX_DIM);
		end else begin
			return SZ_W'(s);
		end
	endfunction

	// A position left beyond a shrunken size sits on the last voxel.
	function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p,
		input logic [SZ_W-1:0] s);
		if (SZ_W'(p) >= s) begin
			return POS_W'(s - SZ_W'(1));
		end else begin
			return p;
		end
	endfunction

	// Register writes; the port always takes a beat.
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid & cfg.ready;

	always_comb begin
		unique case (cfg.index) inside
			REG_AXIS_MODE, REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: cfg_hit = 1'b1;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q   <= AXIS_X;
			size_x_q <= SIZE_CFG_W'(1);
			size_y_q <= SIZE_CFG_W'(1);
			size_z_q <= SIZE_CFG_W'(1);
		end else if (cfg_wr) begin
			unique case (cfg.index)
				REG_AXIS_MODE: axis_q <= cfg.data[AXIS_W-1:0];
				REG_SIZE_X: size_x_q <= cfg.data[SIZE_CFG_W-1:0];
				REG_SIZE_Y: size_y_q <= cfg.data[SIZE_CFG_W-1:0];
				REG_SIZE_Z: size_z_q <= cfg.data[SIZE_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Decode the incoming voxel: line address, first and last of line.
	always_comb begin
		sx     = clamp_size(size_x_q);
		sy     = clamp_size(size_y_q);
		sz     = clamp_size(size_z_q);
		x_s0   = clamp_pos(pos_x_q, sx);
		y_s0   = clamp_pos(pos_y_q, sy);
		z_s0   = clamp_pos(pos_z_q, sz);
		last_x = (SZ_W'(x_s0) == sx - SZ_W'(1));
		last_y = (SZ_W'(y_s0) == sy - SZ_W'(1));
		last_z = (SZ_W'(z_s0) == sz - SZ_W'(1));
		done_s0 = last_x & last_y & last_z;
		case (axis_q)
			AXIS_X: begin
				addr_s0  = '0;
				first_s0 = (x_s0 == '0);
				emit_s0  = last_x;
				len_s0   = sx;
			end
			AXIS_Y: begin
				addr_s0  = ADDR_W'(x_s0);
				first_s0 = (y_s0 == '0);
				emit_s0  = last_y;
				len_s0   = sy;
			end
			default: begin
				addr_s0  = {y_s0, x_s0};
				first_s0 = (z_s0 == '0);
				emit_s0  = last_z;
				len_s0   = sz;
			end
		endcase
	end

	// Raster step to the next position.
	always_comb begin
		nx_x = x_s0;
		nx_y = y_s0;
		nx_z = z_s0;
		if (!last_x) begin
			nx_x = x_s0 + POS_W'(1);
		end else begin
			nx_x = '0;
			if (!last_y) begin
				nx_y = y_s0 + POS_W'(1);
			end else begin
				nx_y = '0;
				nx_z = last_z ? '0 : z_s0 + POS_W'(1);
			end
		end
	end

	assign voxel.ready = !valid_s1 || s1_fire;
	assign voxel_acc   = voxel.valid & voxel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (cfg_wr && cfg_hit) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (voxel_acc) begin
			pos_x_q <= nx_x;
			pos_y_q <= nx_y;
			pos_z_q <= nx_z;
		end
	end

	// Accumulate stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (voxel_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Accumulate stage payload; a write to the same line in this cycle is forwarded.
	always_ff @(posedge clk) begin
		if (voxel_acc) begin
			addr_s1     <= addr_s0;
			val_s1      <= voxel.voxel_value;
			first_s1    <= first_s0;
			emit_s1     <= emit_s0;
			done_s1     <= done_s0;
			len_s1      <= len_s0;
			fwd_s1      <= s1_fire && (addr_s1 == addr_s0);
			fwd_data_s1 <= sum_s1;
		end
	end

	// Sum memory: read when a voxel enters, write when the stage retires.
	always_ff @(posedge clk) begin
		if (voxel_acc) begin
			rdata_s1 <= sums_mem[addr_s0];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			sums_mem[addr_s1] <= sum_s1;
		end
	end

	// The first voxel of a line starts a fresh sum.
	always_comb begin
		if (first_s1) begin
			sum_s1 = SUM_W'(val_s1);
		end else if (fwd_s1) begin
			sum_s1 = fwd_data_s1 + SUM_W'(val_s1);
		end else begin
			sum_s1 = rdata_s1 + SUM_W'(val_s1);
		end
	end

	// A line end waits for the divider to be free.
	assign s1_fire = valid_s1 && (!emit_s1 || div_stat.idle);

	always_comb begin
		div_ctl.start      = s1_fire && emit_s1;
		div_ctl.image_done = done_s1;
		div_ctl.take       = div_stat.valid && out_take;
	end

	amip_div #(
		.SUM_W (SUM_W),
		.SZ_W  (SZ_W),
		.Q_W   (SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (sum_s1),
		.divisor  (len_s1),
		.stat     (div_stat),
		.quotient (div_q)
	);

	// Output register between the divider and the pixel channel.
	assign out_take = !out_valid_q || pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= div_stat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ctl.take) begin
			out_mean_q <= div_q;
			out_done_q <= div_stat.image_done;
		end
	end

	assign pixel.valid      = out_valid_q;
	assign pixel.mean_value = out_mean_q;
	assign pixel.image_done = out_done_q;

	// A stalled line end must keep its memory read data.
	`AMIP_ASSERT_NEXT(a_stall_holds_read, valid_s1 && !s1_fire, valid_s1 && $stable(rdata_s1), "accumulate stage lost its read data while stalled")

	// The last voxel of the volume returns the raster position to the origin.
	`AMIP_ASSERT_NEXT(a_volume_wraps, voxel_acc && done_s0, pos_x_q == '0 && pos_y_q == '0 && pos_z_q == '0, "position did not wrap after the last voxel")

	// The divider is only started from its idle state.
	`AMIP_ASSERT_ALWAYS(a_div_start_idle, !div_ctl.start || div_stat.idle, "divider started while busy")

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of axis_mean_intensity_projection
// Streams voxel volumes under several axis and size settings and checks
// every projected pixel against a behavioral model of the line means.
// ----------------------------------------------------------------------------
module tb;
	import amip_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM          = MAX_DIM_DEF;
	localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
	localparam int SUM_W        = SAMPLE_W + 8;
	localparam int DRAIN_CYCLES = SUM_W + 8;
	localparam int RANDOM_ITEMS = 950;
	localparam int CYCLE_LIMIT  = 500000;

	// Register indexes that map to nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	// Reserved axis code, which projects along z.
	localparam logic [AXIS_W-1:0] AXIS_RESERVED = 2'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean;
		logic                done;
	} pixel_t;

	logic clk;
	logic arst_n;
	bit   steady;
	int   errors;
	int   cycle_count;

	amip_cfg_if                             cfg_ch ();
	amip_voxel_if #(.SAMPLE_BITS(SAMPLE_W)) voxel_ch ();
	amip_pixel_if #(.SAMPLE_BITS(SAMPLE_W)) pixel_ch ();

	axis_mean_intensity_projection #(
		.MAX_DIM    (DIM),
		.SAMPLE_BITS(SAMPLE_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch.sink),
		.voxel (voxel_ch.sink),
		.pixel (pixel_ch.source)
	);

	// Projection model state: registers, raster position and line sums.
	logic [AXIS_W-1:0]     proj_axis;
	logic [SIZE_CFG_W-1:0] proj_sx, proj_sy, proj_sz;
	int                    pos_x, pos_y, pos_z;
	logic [SUM_W-1:0]      line_sums [DIM*DIM];
	pixel_t                pending_pixels [$];

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run length guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Effective extent of a size register: 0 acts as 1, large values saturate.
	function automatic int eff_size(input logic [SIZE_CFG_W-1:0] s);
		if (s == 0)
			return 1;
		if (s > DIM)
			return DIM;
		return int'(s);
	endfunction

	// Register write as the block sees it; mapped writes restart the volume.
	task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_AXIS_MODE: proj_axis = data[AXIS_W-1:0];
			REG_SIZE_X:    proj_sx = data[SIZE_CFG_W-1:0];
			REG_SIZE_Y:    proj_sy = data[SIZE_CFG_W-1:0];
			REG_SIZE_Z:    proj_sz = data[SIZE_CFG_W-1:0];
			default:       return;
		endcase
		pos_x = 0;
		pos_y = 0;
		pos_z = 0;
	endtask

	// Accumulate one voxel into its line and queue the pixel if the line ends.
	task automatic project_voxel(input logic [SAMPLE_W-1:0] v);
		int               sx, sy, sz, x, y, z, addr, len;
		logic             lx, ly, lz, first, emit;
		logic [SUM_W-1:0] sum;
		logic [31:0]      quot;
		pixel_t           pix;
		sx = eff_size(proj_sx);
		sy = eff_size(proj_sy);
		sz = eff_size(proj_sz);
		x = (pos_x >= sx) ? sx - 1 : pos_x;
		y = (pos_y >= sy) ? sy - 1 : pos_y;
		z = (pos_z >= sz) ? sz - 1 : pos_z;
		lx = (x == sx - 1);
		ly = (y == sy - 1);
		lz = (z == sz - 1);
		if (proj_axis == AXIS_X) begin
			addr = 0;
			first = (x == 0);
			emit = lx;
			len = sx;
		end else if (proj_axis == AXIS_Y) begin
			addr = x;
			first = (y == 0);
			emit = ly;
			len = sy;
		end else begin
			addr = y * DIM + x;
			first = (z == 0);
			emit = lz;
			len = sz;
		end
		sum = first ? SUM_W'(v) : line_sums[addr] + SUM_W'(v);
		line_sums[addr] = sum;
		if (emit) begin
			quot = 32'(sum) / 32'(len);
			pix.mean = quot[SAMPLE_W-1:0];
			pix.done = lx && ly && lz;
			pending_pixels.push_back(pix);
		end
		// Advance the raster position.
		if (!lx) begin
			x++;
		end else begin
			x = 0;
			if (!ly) begin
				y++;
			end else begin
				y = 0;
				z = lz ? 0 : z + 1;
			end
		end
		pos_x = x;
		pos_y = y;
		pos_z = z;
	endtask

	// Pixel sink: random back-pressure unless steady, and a check of every accepted beat.
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (!arst_n) begin
			pixel_ch.ready <= 1'b0;
		end else begin
			if (pixel_ch.valid && pixel_ch.ready) begin
				if (pending_pixels.size() == 0) begin
					$display("%0t: unexpected pixel, expected none, actual mean %0d done %0b",
						$time, pixel_ch.mean_value, pixel_ch.image_done);
					errors++;
				end else begin
					want = pending_pixels.pop_front();
					if (pixel_ch.mean_value !== want.mean) begin
						$display("%0t: mean_value expected %0d actual %0d",
							$time, want.mean, pixel_ch.mean_value);
						errors++;
					end
					if (pixel_ch.image_done !== want.done) begin
						$display("%0t: image_done expected %0b actual %0b",
							$time, want.done, pixel_ch.image_done);
						errors++;
					end
				end
			end
			pixel_ch.ready <= steady || ($urandom_range(0, 99) >= 8);
		end
	end

	// Send one voxel beat, with occasional idle cycles ahead of it unless steady.
	task automatic send_voxel(input logic [SAMPLE_W-1:0] v);
		while (!steady && $urandom_range(0, 99) < 8) begin
			voxel_ch.valid <= 1'b0;
			@(posedge clk);
		end
		voxel_ch.valid <= 1'b1;
		voxel_ch.voxel_value <= v;
		@(posedge clk);
		while (!voxel_ch.ready)
			@(posedge clk);
		project_voxel(v);
	endtask

	// Wait until every queued pixel has come out and the divider has settled.
	task automatic wait_drained();
		voxel_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write beat, issued only once the block is idle.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		apply_reg(idx, data);
	endtask

	task automatic set_volume(input logic [AXIS_W-1:0] axis, input logic [SIZE_CFG_W-1:0] sx,
			input logic [SIZE_CFG_W-1:0] sy, input logic [SIZE_CFG_W-1:0] sz);
		write_reg(REG_AXIS_MODE, CFG_DATA_W'(axis));
		write_reg(REG_SIZE_X, sx);
		write_reg(REG_SIZE_Y, sy);
		write_reg(REG_SIZE_Z, sz);
	endtask

	// Registers at their reset values: every voxel is a whole image.
	task automatic test_reset_defaults();
		send_voxel('0);
		send_voxel('1);
	endtask

	// Projection along x with a truncating mean of full-scale voxels.
	task automatic test_axis_x();
		set_volume(AXIS_X, 9'd3, 9'd2, 9'd1);
		send_voxel('1);
		send_voxel('1);
		send_voxel(16'd1);
		send_voxel('0);
		send_voxel('0);
		send_voxel(16'd2);
	endtask

	task automatic test_axis_y();
		set_volume(AXIS_Y, 9'd2, 9'd2, 9'd1);
		send_voxel('1);
		send_voxel(16'd1);
		send_voxel('1);
		send_voxel(16'd2);
	endtask

	// Projection along z, then the reserved axis code with a zero x size.
	task automatic test_axis_z_and_reserved();
		set_volume(AXIS_Z, 9'd2, 9'd1, 9'd2);
		send_voxel('1);
		send_voxel(16'd7);
		send_voxel('1);
		send_voxel(16'd8);
		set_volume(AXIS_RESERVED, 9'd0, 9'd1, 9'd2);
		send_voxel(16'h8001);
		send_voxel(16'h7FFE);
	endtask

	// A mapped write mid-line restarts the volume; an unmapped one does not.
	task automatic test_restart_and_unmapped();
		set_volume(AXIS_X, 9'd4, 9'd1, 9'd1);
		send_voxel('1);
		send_voxel('1);
		write_reg(REG_SIZE_X, 9'd4);
		send_voxel(16'd1);
		send_voxel(16'd2);
		send_voxel(16'd3);
		send_voxel(16'd4);
		send_voxel(16'd100);
		send_voxel(16'd200);
		write_reg(REG_UNMAPPED_LO + 3'd1, '1);
		send_voxel(16'd300);
		send_voxel(16'd400);
	endtask

	// Random volumes: mostly small, now and then one long axis, some cut short.
	task automatic test_random_volumes();
		int                    sent, phase, vol, count, dim;
		logic [AXIS_W-1:0]     axis;
		logic [SIZE_CFG_W-1:0] sx, sy, sz, big;
		logic [SAMPLE_W-1:0]   v;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = (phase >= 4 && phase < 10);
			axis = AXIS_W'($urandom_range(0, 3));
			sx = SIZE_CFG_W'($urandom_range(0, 5));
			sy = SIZE_CFG_W'($urandom_range(0, 5));
			sz = SIZE_CFG_W'($urandom_range(0, 5));
			if (phase == 0) begin
				axis = AXIS_X;
				sx = '1;
				sy = 9'd1;
				sz = 9'd1;
			end else if ($urandom_range(0, 11) == 0) begin
				big = $urandom_range(0, 1) ? SIZE_CFG_W'(DIM) :
					SIZE_CFG_W'($urandom_range(DIM + 1, 511));
				dim = $urandom_range(0, 2);
				sx = (dim == 0) ? big : 9'd1;
				sy = (dim == 1) ? big : 9'd1;
				sz = (dim == 2) ? big : 9'd1;
			end
			set_volume(axis, sx, sy, sz);
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_INDEX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
					CFG_DATA_W'($urandom));
			vol = eff_size(sx) * eff_size(sy) * eff_size(sz);
			count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, vol) : vol;
			repeat (count) begin
				case ($urandom_range(0, 7))
					0:       v = '0;
					1:       v = '1;
					default: v = SAMPLE_W'($urandom);
				endcase
				send_voxel(v);
			end
			sent += count;
			phase++;
		end
		steady = 1'b0;
	endtask

	// Reset, test sequence and verdict.
	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		errors = 0;
		cycle_count = 0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		voxel_ch.valid = 1'b0;
		voxel_ch.voxel_value = '0;
		pixel_ch.ready = 1'b0;
		proj_axis = AXIS_X;
		proj_sx = 9'd1;
		proj_sy = 9'd1;
		proj_sz = 9'd1;
		pos_x = 0;
		pos_y = 0;
		pos_z = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_axis_x();
		test_axis_y();
		test_axis_z_and_reserved();
		test_restart_and_unmapped();
		test_random_volumes();

		wait_drained();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/amip_pkg.sv
rtl/core/amip_ifs.sv
rtl/core/amip_div.sv
rtl/core/axis_mean_intensity_projection.sv
tb/sv/tb.sv
